// File: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int SEG_W   = 16;
    localparam int COUNT_W = 11;
    localparam int FIELD_W = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_SEGMENT_BYTES  = 1'b0;
    localparam logic REG_ARENA_SEGMENTS = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic [SEG_W-1:0]   SEGMENT_BYTES_RESET  = 16'd64;
    localparam logic [COUNT_W-1:0] ARENA_SEGMENTS_RESET = 11'd64;

    typedef struct packed {
        logic start;
        logic finish;
    } fbpa_cmd_t;

endpackage

// File: rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencing: accept, memory read cycle, output register handoff.
// ----------------------------------------------------------------------------
module fbpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output fbpa_pkg::fbpa_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.start      = in_valid && (state_reg == ST_IDLE);
        cmd.finish     = (state_reg == ST_BUSY) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (cmd.finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// fbpa_datapath
// Config registers, bump pointer, free stack memory and result registers.
// ----------------------------------------------------------------------------
module fbpa_datapath
#(
    parameter int FREE_DEPTH   = 1024,
    parameter int HEADER_BYTES = 8,
    parameter int ADDR_BITS    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  fbpa_pkg::fbpa_cmd_t cmd,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                command,
    input  logic [15:0]         request_size,
    input  logic [15:0]         free_address,
    output logic                granted,
    output logic [15:0]         address,
    output logic [1:0]          status,
    output logic [10:0]         available,
    output logic                all_free
);

    localparam int CNT_W   = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W   = $clog2(FREE_DEPTH);
    localparam int AVAIL_W = ((CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W) + 1;
    localparam int SEG_W   = fbpa_pkg::SEG_W;
    localparam int CW      = fbpa_pkg::COUNT_W;

    logic [SEG_W-1:0]     seg_bytes_reg;
    logic [CW-1:0]        arena_reg;
    logic [ADDR_BITS-1:0] bump_reg;
    logic [ADDR_BITS-1:0] bump_next;
    logic [CW-1:0]        used_reg;
    logic [CW-1:0]        used_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic [ADDR_BITS-1:0] mem [FREE_DEPTH];
    logic [ADDR_BITS-1:0] rdata_reg;

    logic [SEG_W-1:0]     payload_max;
    logic                 too_large;
    logic                 pop;
    logic                 push;
    logic [1:0]           status_now;
    logic                 granted_now;
    logic [CW-1:0]        untouched;
    logic [AVAIL_W-1:0]   avail;

    logic                 pop_reg;
    logic                 granted_reg;
    logic [1:0]           status_reg;
    logic [ADDR_BITS-1:0] bump_addr_reg;
    logic [CW-1:0]        avail_reg;
    logic                 all_free_reg;

    logic                 granted_out_reg;
    logic [15:0]          address_out_reg;
    logic [1:0]           status_out_reg;
    logic [CW-1:0]        available_out_reg;
    logic                 all_free_out_reg;

    always_comb
    begin
        payload_max = (seg_bytes_reg >= SEG_W'(HEADER_BYTES)) ?
                      seg_bytes_reg - SEG_W'(HEADER_BYTES) : '0;
        too_large   = (request_size != '0) && (request_size > payload_max);
        bump_next   = bump_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        pop         = 1'b0;
        push        = 1'b0;
        granted_now = 1'b0;
        status_now  = fbpa_pkg::STATUS_OK;
        if (command == fbpa_pkg::CMD_ALLOC)
        begin
            if (too_large)
            begin
                status_now = fbpa_pkg::STATUS_TOO_LARGE;
            end
            else if (used_reg < arena_reg)
            begin
                bump_next   = bump_reg + ADDR_BITS'(seg_bytes_reg);
                used_next   = used_reg + CW'(1);
                granted_now = 1'b1;
            end
            else if (count_reg != '0)
            begin
                count_next  = count_reg - CNT_W'(1);
                pop         = 1'b1;
                granted_now = 1'b1;
            end
            else
            begin
                status_now = fbpa_pkg::STATUS_EXHAUSTED;
            end
        end
        else
        begin
            if (count_reg == CNT_W'(FREE_DEPTH))
            begin
                status_now = fbpa_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                push       = 1'b1;
            end
        end
        untouched = (used_next < arena_reg) ? arena_reg - used_next : '0;
        avail     = AVAIL_W'(count_next) + AVAIL_W'(untouched);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && push)
        begin
            mem[IDX_W'(count_reg)] <= ADDR_BITS'(free_address);
        end
        if (cmd.start && pop)
        begin
            rdata_reg <= mem[IDX_W'(count_reg - CNT_W'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_bytes_reg <= fbpa_pkg::SEGMENT_BYTES_RESET;
            arena_reg     <= fbpa_pkg::ARENA_SEGMENTS_RESET;
            bump_reg      <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fbpa_pkg::REG_SEGMENT_BYTES:  seg_bytes_reg <= cfg_data;
                    fbpa_pkg::REG_ARENA_SEGMENTS: arena_reg     <= cfg_data[CW-1:0];
                    default:                      seg_bytes_reg <= seg_bytes_reg;
                endcase
            end
            if (cmd.start)
            begin
                bump_reg  <= bump_next;
                used_reg  <= used_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pop_reg       <= pop;
            granted_reg   <= granted_now;
            status_reg    <= status_now;
            bump_addr_reg <= (granted_now && !pop) ?
                             bump_reg + ADDR_BITS'(HEADER_BYTES) : '0;
            avail_reg     <= avail[CW-1:0];
            all_free_reg  <= (avail == AVAIL_W'(arena_reg));
        end
        if (cmd.finish)
        begin
            granted_out_reg   <= granted_reg;
            address_out_reg   <= pop_reg ? 16'(rdata_reg) : 16'(bump_addr_reg);
            status_out_reg    <= status_reg;
            available_out_reg <= avail_reg;
            all_free_out_reg  <= all_free_reg;
        end
    end

    assign granted   = granted_out_reg;
    assign address   = address_out_reg;
    assign status    = status_out_reg;
    assign available = available_out_reg;
    assign all_free  = all_free_out_reg;

endmodule

// File: rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool allocator with bump pointer and LIFO free stack.
// ----------------------------------------------------------------------------
// A request passes through an accept cycle, which decides the outcome and
// updates the pointers, and a busy state, which waits on the registered read
// of the free stack memory and on a free output register before the result
// enters the output register. A new request is accepted as soon as the
// previous result has been loaded, even if that result is still waiting for
// out_ready. Configuration writes (index 0 segment_bytes, index 1
// arena_segments) must only be issued while the block is idle. No clearing
// pass after reset; the free stack is only ever read below its fill count.
module fixed_block_pool_allocator
#(
    parameter int FREE_DEPTH   = 1024,
    parameter int HEADER_BYTES = 8,
    parameter int ADDR_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [15:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        granted,
    output logic [15:0] address,
    output logic [1:0]  status,
    output logic [10:0] available,
    output logic        all_free
);

    fbpa_pkg::fbpa_cmd_t cmd;

    fbpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fbpa_datapath
    #(
        .FREE_DEPTH   (FREE_DEPTH),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .request_size (request_size),
        .free_address (free_address),
        .granted      (granted),
        .address      (address),
        .status       (status),
        .available    (available),
        .all_free     (all_free)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in flight");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> status == fbpa_pkg::STATUS_OK)
        else $error("grant with non-ok status");

    a_no_grant_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> address == 16'd0)
        else $error("nonzero address without grant");
`endif

endmodule
